[design/ftt_pkg.sv]
package ftt_pkg;

    localparam int MAX_LEVELS       = 8;
    localparam int LEVEL_CAP        = (MAX_LEVELS < 8) ? MAX_LEVELS : 8;
    localparam int WALK_DEPTH       = 8;
    localparam int DEF_MAX_ALLELES  = 16;
    localparam int DEF_NODE_SLOTS   = 256;
    localparam int DEF_LEAF_SLOTS   = 4096;

    localparam int PATH_W     = 32;
    localparam int FIELD_W    = 4;
    localparam int DEPTH_W    = 4;
    localparam int LVL_W      = 3;
    localparam int TOP_W      = 4;
    localparam int ALLELE_W   = 5;
    localparam int LEAF_OUT_W = 12;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ALLELES     = CFG_IDX_W'(1);

    localparam logic [DEPTH_W-1:0]    LEVEL_COUNT_RST = DEPTH_W'(8);
    localparam logic [PATH_W-1:0]     ALLELES_RST     = '1;
    // walk position of a level not yet entered
    localparam logic [ALLELE_W-1:0]   ALLELE_NONE     = '1;

    typedef enum logic [1:0] {
        REQ_CLEAR,
        REQ_INSERT,
        REQ_RESTART,
        REQ_NEXT
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_END,
        ST_FULL,
        ST_RANGE
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_EV,
        S_INS_WR,
        S_NXT_SCAN,
        S_NXT_EV,
        S_RESP
    } core_state_t;

    typedef struct packed {
        req_type_t           req_type;
        logic [PATH_W-1:0]   path_in;
    } trie_req_t;

    typedef struct packed {
        logic [LEAF_OUT_W-1:0] leaf_index;
        logic [PATH_W-1:0]     path_out;
        status_t               status;
    } trie_rsp_t;

    // allele count of one level, capped
    function automatic logic [ALLELE_W-1:0] allele_cnt(
        input logic [PATH_W-1:0]   apl,
        input logic [LVL_W-1:0]    lvl,
        input logic [ALLELE_W-1:0] cap
    );
        logic [ALLELE_W-1:0] c;
        c = {1'b0, apl[lvl*FIELD_W +: FIELD_W]} + ALLELE_W'(1);
        if (c > cap)
        begin
            c = cap;
        end
        return c;
    endfunction

endpackage

[design/ftt_ram.sv]
module ftt_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[design/ftt_clr.sv]
module ftt_clr #(
    parameter int DEPTH = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [$clog2(DEPTH+1)-1:0] len,
    output logic                       busy,
    output logic [$clog2(DEPTH)-1:0]   wr_addr
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] addr_reg, addr_next;
    logic [CNT_W-1:0] end_reg, end_next;

    always_comb
    begin
        busy_next = busy_reg;
        addr_next = addr_reg;
        end_next  = end_reg;
        if (busy_reg)
        begin
            addr_next = addr_reg + CNT_W'(1);
            if (addr_next == end_reg)
            begin
                busy_next = 1'b0;
            end
        end
        else if (start && (len != '0))
        begin
            busy_next = 1'b1;
            addr_next = '0;
            end_next  = len;
        end
    end

    // after reset the whole store is swept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            addr_reg <= '0;
            end_reg  <= CNT_W'(DEPTH);
        end
        else
        begin
            busy_reg <= busy_next;
            addr_reg <= addr_next;
            end_reg  <= end_next;
        end
    end

    assign busy    = busy_reg;
    assign wr_addr = addr_reg[ADDR_W-1:0];

endmodule

[design/ftt_core.sv]
module ftt_core
    import ftt_pkg::*;
#(
    parameter int NODE_SLOTS  = DEF_NODE_SLOTS,
    parameter int LEAF_SLOTS  = DEF_LEAF_SLOTS,
    parameter int MAX_ALLELES = DEF_MAX_ALLELES
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          req_valid,
    output logic                                          req_stall,
    input  trie_req_t                                     req,
    output logic                                          rsp_valid,
    input  logic                                          rsp_stall,
    output trie_rsp_t                                     rsp,
    input  logic                                          cfg_clear,
    input  logic [DEPTH_W-1:0]                            depth,
    input  logic [PATH_W-1:0]                             apl,
    input  logic                                          clr_busy,
    output logic                                          clr_start,
    output logic [$clog2(NODE_SLOTS*MAX_ALLELES+1)-1:0]   clr_len,
    output logic [$clog2(NODE_SLOTS*MAX_ALLELES)-1:0]     ram_addr,
    output logic                                          ram_wr_en,
    output logic [$clog2(((NODE_SLOTS > LEAF_SLOTS) ? NODE_SLOTS : LEAF_SLOTS) + 1)-1:0]
                                                          ram_wr_data,
    input  logic [$clog2(((NODE_SLOTS > LEAF_SLOTS) ? NODE_SLOTS : LEAF_SLOTS) + 1)-1:0]
                                                          ram_rd_data
);

    localparam int NODE_W     = $clog2(NODE_SLOTS);
    localparam int NCNT_W     = $clog2(NODE_SLOTS + 1);
    localparam int LCNT_W     = $clog2(LEAF_SLOTS + 1);
    localparam int LINK_DEPTH = NODE_SLOTS * MAX_ALLELES;
    localparam int ADDR_W     = $clog2(LINK_DEPTH);
    localparam int CLR_W      = $clog2(LINK_DEPTH + 1);
    localparam int LINK_MAX   = (NODE_SLOTS > LEAF_SLOTS) ? NODE_SLOTS : LEAF_SLOTS;
    localparam int LINK_W     = $clog2(LINK_MAX + 1);
    localparam int ALLELE_CAP = (MAX_ALLELES < 16) ? MAX_ALLELES : 16;
    localparam logic [ALLELE_W-1:0] CAP = ALLELE_W'(ALLELE_CAP);

    core_state_t          state_reg, state_next;
    logic [PATH_W-1:0]    path_reg, path_next;
    logic [LVL_W-1:0]     lvl_reg, lvl_next;
    logic [LINK_W-1:0]    cur_reg, cur_next;
    logic [NCNT_W-1:0]    node_used_reg, node_used_next;
    logic [LCNT_W-1:0]    leaf_used_reg, leaf_used_next;
    logic [NODE_W-1:0]    stack_reg [WALK_DEPTH];
    logic [NODE_W-1:0]    stack_next [WALK_DEPTH];
    logic [ALLELE_W-1:0]  alle_reg [WALK_DEPTH];
    logic [ALLELE_W-1:0]  alle_next [WALK_DEPTH];
    logic [TOP_W-1:0]     top_reg, top_next;
    logic [ALLELE_W-1:0]  a_reg, a_next;
    trie_rsp_t            res_reg, res_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    trie_rsp_t            rsp_reg, rsp_next;

    logic                 acc;
    logic                 out_free;
    logic                 rng_err;
    logic [DEPTH_W-1:0]   need;
    logic [NCNT_W:0]      nsum;
    logic                 full;
    logic [FIELD_W-1:0]   al_cur;
    logic [LVL_W-1:0]     tl;
    logic [ALLELE_W-1:0]  a_scan;
    logic [ALLELE_W-1:0]  cnt_scan;
    logic                 lk_zero;
    logic                 ins_last;
    logic                 nxt_last;
    logic                 top_zero;
    logic                 top_full;
    logic                 scan_done;
    logic [NODE_W-1:0]    node_sel;
    logic [ALLELE_W-1:0]  allele_sel;

    assign acc      = req_valid && !req_stall;
    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rng_err = 1'b0;
        for (int i = 0; i < WALK_DEPTH; i++)
        begin
            if ((DEPTH_W'(i) < depth) &&
                ({1'b0, req.path_in[i*FIELD_W +: FIELD_W]} >= allele_cnt(apl, LVL_W'(i), CAP)))
            begin
                rng_err = 1'b1;
            end
        end
    end

    // shared capacity check: a fresh root needs the whole path, otherwise what lies below
    assign need = (state_reg == S_IDLE) ? depth
                                        : depth - DEPTH_W'(1) - DEPTH_W'(lvl_reg);
    assign nsum = (NCNT_W + 1)'(node_used_reg) + (NCNT_W + 1)'(need);
    assign full = (nsum > (NCNT_W + 1)'(NODE_SLOTS)) ||
                  (leaf_used_reg == LCNT_W'(LEAF_SLOTS));

    assign al_cur    = path_reg[lvl_reg*FIELD_W +: FIELD_W];
    // a node on the walk stack sits at the level of its stack position
    assign tl        = LVL_W'(top_reg - TOP_W'(1));
    assign a_scan    = alle_reg[tl] + ALLELE_W'(1);
    assign cnt_scan  = allele_cnt(apl, tl, CAP);
    assign scan_done = a_scan >= cnt_scan;
    assign lk_zero   = ram_rd_data == '0;
    assign ins_last  = DEPTH_W'(lvl_reg) == (depth - DEPTH_W'(1));
    assign nxt_last  = DEPTH_W'(tl) >= (depth - DEPTH_W'(1));
    assign top_zero  = top_reg == '0;
    assign top_full  = top_reg >= TOP_W'(WALK_DEPTH);

    always_comb
    begin
        if ((state_reg == S_NXT_SCAN) || (state_reg == S_NXT_EV))
        begin
            node_sel   = stack_reg[tl];
            allele_sel = a_scan;
        end
        else
        begin
            node_sel   = cur_reg[NODE_W-1:0];
            allele_sel = {1'b0, al_cur};
        end
    end

    assign ram_addr = ADDR_W'(node_sel) * ADDR_W'(MAX_ALLELES) + ADDR_W'(allele_sel);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    case (req.req_type)
                        REQ_INSERT:
                        begin
                            if (rng_err)
                            begin
                                state_next = S_RESP;
                            end
                            else if (node_used_reg == '0)
                            begin
                                state_next = full ? S_RESP : S_INS_WR;
                            end
                            else
                            begin
                                state_next = S_INS_RD;
                            end
                        end
                        REQ_NEXT: state_next = S_NXT_SCAN;
                        default:  state_next = S_RESP;
                    endcase
                end
            end
            S_INS_RD: state_next = S_INS_EV;
            S_INS_EV:
            begin
                if (!lk_zero)
                begin
                    state_next = ins_last ? S_RESP : S_INS_RD;
                end
                else
                begin
                    state_next = full ? S_RESP : S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                if (ins_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_NXT_SCAN:
            begin
                if (top_zero)
                begin
                    state_next = S_RESP;
                end
                else if (!scan_done)
                begin
                    state_next = S_NXT_EV;
                end
            end
            S_NXT_EV:
            begin
                if (!lk_zero && (nxt_last || top_full))
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_NXT_SCAN;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        path_next      = path_reg;
        lvl_next       = lvl_reg;
        cur_next       = cur_reg;
        node_used_next = node_used_reg;
        leaf_used_next = leaf_used_reg;
        top_next       = top_reg;
        a_next         = a_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        for (int i = 0; i < WALK_DEPTH; i++)
        begin
            stack_next[i] = stack_reg[i];
            alle_next[i]  = alle_reg[i];
        end
        clr_start   = 1'b0;
        clr_len     = CLR_W'(node_used_reg) * CLR_W'(MAX_ALLELES);
        ram_wr_en   = 1'b0;
        ram_wr_data = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    res_next  = '0;
                    path_next = req.path_in;
                    lvl_next  = '0;
                    cur_next  = '0;
                    case (req.req_type)
                        REQ_CLEAR:
                        begin
                            clr_start      = 1'b1;
                            node_used_next = '0;
                            leaf_used_next = '0;
                            top_next       = TOP_W'(1);
                            for (int i = 0; i < WALK_DEPTH; i++)
                            begin
                                stack_next[i] = '0;
                                alle_next[i]  = ALLELE_NONE;
                            end
                        end
                        REQ_INSERT:
                        begin
                            if (rng_err)
                            begin
                                res_next.status = ST_RANGE;
                            end
                            else if (node_used_reg == '0)
                            begin
                                if (full)
                                begin
                                    res_next.status = ST_FULL;
                                end
                                else
                                begin
                                    node_used_next = NCNT_W'(1);
                                end
                            end
                        end
                        REQ_RESTART:
                        begin
                            top_next = TOP_W'(1);
                            for (int i = 0; i < WALK_DEPTH; i++)
                            begin
                                stack_next[i] = '0;
                                alle_next[i]  = ALLELE_NONE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_INS_EV:
            begin
                if (!lk_zero)
                begin
                    cur_next = ram_rd_data - LINK_W'(1);
                    if (ins_last)
                    begin
                        res_next.leaf_index = LEAF_OUT_W'(ram_rd_data - LINK_W'(1));
                    end
                    else
                    begin
                        lvl_next = lvl_reg + LVL_W'(1);
                    end
                end
                else if (full)
                begin
                    res_next.status = ST_FULL;
                end
            end
            S_INS_WR:
            begin
                ram_wr_en = 1'b1;
                if (!ins_last)
                begin
                    ram_wr_data    = LINK_W'(node_used_reg) + LINK_W'(1);
                    cur_next       = LINK_W'(node_used_reg);
                    node_used_next = node_used_reg + NCNT_W'(1);
                    lvl_next       = lvl_reg + LVL_W'(1);
                end
                else
                begin
                    ram_wr_data         = LINK_W'(leaf_used_reg) + LINK_W'(1);
                    leaf_used_next      = leaf_used_reg + LCNT_W'(1);
                    res_next.leaf_index = LEAF_OUT_W'(leaf_used_reg);
                end
            end
            S_NXT_SCAN:
            begin
                a_next = a_scan;
                if (top_zero)
                begin
                    res_next.status = ST_END;
                end
                else if (scan_done)
                begin
                    alle_next[tl] = ALLELE_NONE;
                    top_next      = top_reg - TOP_W'(1);
                end
            end
            S_NXT_EV:
            begin
                // a miss still advances the position so the next probe moves on
                alle_next[tl] = a_reg;
                if (!lk_zero)
                begin
                    if (nxt_last)
                    begin
                        res_next.leaf_index = LEAF_OUT_W'(ram_rd_data - LINK_W'(1));
                        for (int i = 0; i < WALK_DEPTH; i++)
                        begin
                            if (DEPTH_W'(i) < depth)
                            begin
                                res_next.path_out[i*FIELD_W +: FIELD_W] =
                                    (LVL_W'(i) == tl) ? a_reg[FIELD_W-1:0]
                                                      : alle_reg[i][FIELD_W-1:0];
                            end
                        end
                    end
                    else if (top_full)
                    begin
                        top_next        = '0;
                        res_next.status = ST_END;
                    end
                    else
                    begin
                        stack_next[top_reg[LVL_W-1:0]] = NODE_W'(ram_rd_data - LINK_W'(1));
                        top_next = top_reg + TOP_W'(1);
                    end
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                end
            end
            default:
            begin
            end
        endcase

        // a register write empties the store
        if (cfg_clear)
        begin
            clr_start      = 1'b1;
            node_used_next = '0;
            leaf_used_next = '0;
            top_next       = TOP_W'(1);
            for (int i = 0; i < WALK_DEPTH; i++)
            begin
                stack_next[i] = '0;
                alle_next[i]  = ALLELE_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            node_used_reg <= '0;
            leaf_used_reg <= '0;
            top_reg       <= TOP_W'(1);
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < WALK_DEPTH; i++)
            begin
                stack_reg[i] <= '0;
                alle_reg[i]  <= ALLELE_NONE;
            end
        end
        else
        begin
            state_reg     <= state_next;
            node_used_reg <= node_used_next;
            leaf_used_reg <= leaf_used_next;
            top_reg       <= top_next;
            rsp_valid_reg <= rsp_valid_next;
            for (int i = 0; i < WALK_DEPTH; i++)
            begin
                stack_reg[i] <= stack_next[i];
                alle_reg[i]  <= alle_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        path_reg <= path_next;
        lvl_reg  <= lvl_next;
        cur_reg  <= cur_next;
        a_reg    <= a_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE) || clr_busy;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[design/fixed_depth_trie_insert_traverse.sv]
// channel   | direction | handshake            | payload
// req       | in        | req_valid, req_stall | trie_req_t: req_type, path_in
// rsp       | out       | rsp_valid, rsp_stall | trie_rsp_t: leaf_index, path_out, status
// cfg       | in        | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// one transaction at a time. clear, restart and an out-of-range insert go straight to the
// result register; an insert follows existing child links and writes one per new level;
// a next request probes child links, climbing out of spent levels, until it finds a leaf
// or the walk runs out. each probe is one registered read of the child-link RAM. after
// reset the NODE_SLOTS * MAX_ALLELES link RAM entries are swept; a clear or register write
// sweeps nodes-used * MAX_ALLELES entries. req_stall is high in a sweep or a transaction.
module fixed_depth_trie_insert_traverse
    import ftt_pkg::*;
#(
    parameter int NODE_SLOTS  = DEF_NODE_SLOTS,
    parameter int LEAF_SLOTS  = DEF_LEAF_SLOTS,
    parameter int MAX_ALLELES = DEF_MAX_ALLELES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  trie_req_t             req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output trie_rsp_t             rsp,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LINK_DEPTH = NODE_SLOTS * MAX_ALLELES;
    localparam int ADDR_W     = $clog2(LINK_DEPTH);
    localparam int CLR_W      = $clog2(LINK_DEPTH + 1);
    localparam int LINK_MAX   = (NODE_SLOTS > LEAF_SLOTS) ? NODE_SLOTS : LEAF_SLOTS;
    localparam int LINK_W     = $clog2(LINK_MAX + 1);

    logic [DEPTH_W-1:0] level_count_reg, level_count_next;
    logic [PATH_W-1:0]  apl_reg, apl_next;
    logic               cfg_clear;
    logic [DEPTH_W-1:0] depth;

    logic               clr_busy;
    logic               clr_start;
    logic [CLR_W-1:0]   clr_len;
    logic [ADDR_W-1:0]  clr_addr;

    logic [ADDR_W-1:0]  core_addr;
    logic               core_wr_en;
    logic [LINK_W-1:0]  core_wr_data;
    logic [LINK_W-1:0]  ram_rd_data;

    logic               ram_wr_en;
    logic [ADDR_W-1:0]  ram_wr_addr;
    logic [LINK_W-1:0]  ram_wr_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        level_count_next = level_count_reg;
        apl_next         = apl_reg;
        cfg_clear        = 1'b0;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LEVEL_COUNT:
                begin
                    level_count_next = cfg_data[DEPTH_W-1:0];
                    cfg_clear        = 1'b1;
                end
                REG_ALLELES:
                begin
                    apl_next  = cfg_data[PATH_W-1:0];
                    cfg_clear = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_count_reg <= LEVEL_COUNT_RST;
            apl_reg         <= ALLELES_RST;
        end
        else
        begin
            level_count_reg <= level_count_next;
            apl_reg         <= apl_next;
        end
    end

    // path depth held within one and the level cap
    always_comb
    begin
        depth = level_count_reg;
        if (depth == '0)
        begin
            depth = DEPTH_W'(1);
        end
        if (depth > DEPTH_W'(LEVEL_CAP))
        begin
            depth = DEPTH_W'(LEVEL_CAP);
        end
    end

    ftt_clr #(
        .DEPTH (LINK_DEPTH)
    ) u_clr (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (clr_start),
        .len     (clr_len),
        .busy    (clr_busy),
        .wr_addr (clr_addr)
    );

    ftt_core #(
        .NODE_SLOTS  (NODE_SLOTS),
        .LEAF_SLOTS  (LEAF_SLOTS),
        .MAX_ALLELES (MAX_ALLELES)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .cfg_clear   (cfg_clear),
        .depth       (depth),
        .apl         (apl_reg),
        .clr_busy    (clr_busy),
        .clr_start   (clr_start),
        .clr_len     (clr_len),
        .ram_addr    (core_addr),
        .ram_wr_en   (core_wr_en),
        .ram_wr_data (core_wr_data),
        .ram_rd_data (ram_rd_data)
    );

    // the sweep owns the write port while it runs
    assign ram_wr_en   = clr_busy || core_wr_en;
    assign ram_wr_addr = clr_busy ? clr_addr : core_addr;
    assign ram_wr_data = clr_busy ? '0 : core_wr_data;

    ftt_ram #(
        .WIDTH (LINK_W),
        .DEPTH (LINK_DEPTH)
    ) u_links (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (core_addr),
        .rd_data (ram_rd_data)
    );

    a_no_write_in_sweep: assert property (
        @(posedge clk) disable iff (!rst_n) clr_busy |-> !core_wr_en)
        else $error("link write from the walk during a sweep");

    a_stall_in_sweep: assert property (
        @(posedge clk) disable iff (!rst_n) clr_busy |-> req_stall)
        else $error("request taken during a sweep");

    a_end_is_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == ST_END)) |->
            ((rsp.leaf_index == '0) && (rsp.path_out == '0)))
        else $error("end of traversal with a leaf or path");

    a_sweep_only_on_clear: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(clr_busy) |->
            $past(cfg_clear || (req_valid && !req_stall && (req.req_type == REQ_CLEAR))))
        else $error("sweep started without a clear");

endmodule

[dv/tb_fixed_depth_trie_insert_traverse.sv]
`timescale 1ns / 1ps

module tb_fixed_depth_trie_insert_traverse;
    import ftt_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = '1;
    localparam int LONG_HOLD = 400;
    localparam int PHASE_ITEMS = 245;

    localparam trie_rsp_t RSP_NONE  = '{leaf_index: '0, path_out: '0, status: ST_OK};
    localparam trie_rsp_t RSP_ENDED = '{leaf_index: '0, path_out: '0, status: ST_END};
    localparam trie_rsp_t RSP_RANGE = '{leaf_index: '0, path_out: '0, status: ST_RANGE};

    typedef struct {
        bit                    cfg_row;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        req_type_t             kind;
        logic [PATH_W-1:0]     path;
        bit                    typed;
        trie_rsp_t             want;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    trie_req_t             req;
    logic                  rsp_valid;
    logic                  rsp_stall;
    trie_rsp_t             rsp;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predicted trie contents and walk position
    logic [3:0]        cfg_levels;
    logic [PATH_W-1:0] cfg_alleles;
    int unsigned       links [DEF_NODE_SLOTS * DEF_MAX_ALLELES];
    logic [2:0]        lvl_of [DEF_NODE_SLOTS];
    int unsigned       nodes_used;
    int unsigned       leaves_used;
    int unsigned       walk_node [WALK_DEPTH];
    int                walk_pos [WALK_DEPTH];
    int unsigned       walk_sp;

    trie_rsp_t         rsp_due [$];
    logic [PATH_W-1:0] known_paths [$];
    int                err_cnt = 0;
    int                sent = 0;
    bit                nodes_ever = 1'b0;
    bit                quiet = 1'b0;
    int                hold_asks = 0;

    fixed_depth_trie_insert_traverse dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int unsigned depth_eff();
        int unsigned d;
        d = cfg_levels;
        if (d < 1)
        begin
            d = 1;
        end
        if (d > LEVEL_CAP)
        begin
            d = LEVEL_CAP;
        end
        return d;
    endfunction

    function automatic int unsigned allele_limit(int unsigned lvl);
        int unsigned c;
        c = ((cfg_alleles >> (4 * (lvl & 7))) & 15) + 1;
        return (c > DEF_MAX_ALLELES) ? DEF_MAX_ALLELES : c;
    endfunction

    function automatic int unsigned link_rd(int unsigned node, int unsigned allele);
        if (node >= DEF_NODE_SLOTS || allele >= DEF_MAX_ALLELES)
        begin
            return 0;
        end
        return links[node * DEF_MAX_ALLELES + allele];
    endfunction

    function automatic int unsigned alloc_node(int unsigned lvl);
        int unsigned n;
        n = nodes_used;
        if (n < DEF_NODE_SLOTS)
        begin
            lvl_of[n] = 3'(lvl);
        end
        nodes_used++;
        return n;
    endfunction

    function automatic void walk_reset();
        for (int k = 0; k < WALK_DEPTH; k++)
        begin
            walk_node[k] = 0;
            walk_pos[k]  = -1;
        end
        walk_sp = 1;
    endfunction

    function automatic void trie_clear();
        foreach (links[k])
        begin
            links[k] = 0;
        end
        foreach (lvl_of[k])
        begin
            lvl_of[k] = '0;
        end
        nodes_used  = 0;
        leaves_used = 0;
        walk_reset();
    endfunction

    function automatic int unsigned trie_insert(input logic [PATH_W-1:0] path,
                                                output status_t st);
        int unsigned d, i, node, need_n, need_l, lk, child;
        int unsigned al [8];
        d = depth_eff();
        for (i = 0; i < d; i++)
        begin
            al[i] = (path >> (4 * i)) & 15;
            if (al[i] >= allele_limit(i))
            begin
                st = ST_RANGE;
                return 0;
            end
        end
        // work out what the path is missing before touching anything
        if (nodes_used == 0)
        begin
            need_n = d;
            need_l = 1;
        end
        else
        begin
            need_n = 0;
            need_l = 0;
            node = 0;
            for (i = 0; i < d; i++)
            begin
                lk = link_rd(node, al[i]);
                if (lk == 0)
                begin
                    need_n = d - 1 - i;
                    need_l = 1;
                    break;
                end
                node = lk - 1;
            end
        end
        if (nodes_used + need_n > DEF_NODE_SLOTS || leaves_used + need_l > DEF_LEAF_SLOTS)
        begin
            st = ST_FULL;
            return 0;
        end
        if (nodes_used == 0)
        begin
            void'(alloc_node(0));
        end
        node = 0;
        for (i = 0; i < d; i++)
        begin
            lk = link_rd(node, al[i]);
            if (lk == 0)
            begin
                if (i < d - 1)
                begin
                    child = alloc_node(i + 1);
                end
                else
                begin
                    child = leaves_used;
                    leaves_used++;
                end
                lk = child + 1;
                if (node < DEF_NODE_SLOTS && al[i] < DEF_MAX_ALLELES)
                begin
                    links[node * DEF_MAX_ALLELES + al[i]] = lk;
                end
            end
            node = lk - 1;
        end
        st = ST_OK;
        return node;
    endfunction

    function automatic int unsigned trie_next(output logic [PATH_W-1:0] path,
                                              output status_t st);
        int unsigned d, node, lvl, cnt, lk, i;
        int a;
        logic [PATH_W-1:0] p;
        d = depth_eff();
        path = '0;
        st = ST_END;
        while (walk_sp > 0 && walk_sp <= WALK_DEPTH)
        begin
            node = walk_node[walk_sp - 1];
            lvl = (node < DEF_NODE_SLOTS) ? int'(lvl_of[node]) : 0;
            cnt = allele_limit(lvl);
            lk = 0;
            for (a = walk_pos[lvl] + 1; a >= 0 && a < int'(cnt); a++)
            begin
                if (nodes_used > 0)
                begin
                    lk = link_rd(node, a);
                end
                if (lk != 0)
                begin
                    break;
                end
            end
            if (lk == 0)
            begin
                // level exhausted, climb back up
                walk_pos[lvl] = -1;
                walk_sp--;
                continue;
            end
            walk_pos[lvl] = a;
            if (lvl >= d - 1)
            begin
                p = '0;
                for (i = 0; i < d; i++)
                begin
                    p[4 * i +: 4] = walk_pos[i][3:0];
                end
                path = p;
                st = ST_OK;
                return lk - 1;
            end
            if (walk_sp >= WALK_DEPTH)
            begin
                walk_sp = 0;
                break;
            end
            walk_node[walk_sp] = lk - 1;
            walk_sp++;
        end
        walk_sp = 0;
        return 0;
    endfunction

    function automatic trie_rsp_t trie_step(trie_req_t r);
        trie_rsp_t   o;
        int unsigned leaf;
        status_t     st;
        logic [PATH_W-1:0] pout;
        leaf = 0;
        st = ST_OK;
        pout = '0;
        case (r.req_type)
            REQ_CLEAR:   trie_clear();
            REQ_INSERT:  leaf = trie_insert(r.path_in, st);
            REQ_RESTART: walk_reset();
            default:     leaf = trie_next(pout, st);
        endcase
        o.leaf_index = leaf[LEAF_OUT_W-1:0];
        o.path_out   = pout;
        o.status     = st;
        return o;
    endfunction

    function automatic logic [PATH_W-1:0] rand_path(bit legal);
        logic [PATH_W-1:0] p;
        int unsigned d, lv, cnt;
        p = $urandom();
        d = depth_eff();
        for (int i = 0; i < d; i++)
        begin
            p[4 * i +: 4] = 4'($urandom_range(0, allele_limit(i) - 1));
        end
        if (!legal)
        begin
            lv = $urandom_range(0, d - 1);
            cnt = allele_limit(lv);
            if (cnt < DEF_MAX_ALLELES)
            begin
                p[4 * lv +: 4] = 4'($urandom_range(cnt, 15));
            end
        end
        return p;
    endfunction

    // revisit a known path now and then so existing leaves get looked up
    function automatic logic [PATH_W-1:0] pick_path();
        if (known_paths.size() > 0 && $urandom_range(0, 3) == 0)
        begin
            return known_paths[$urandom_range(0, known_paths.size() - 1)];
        end
        return rand_path(1'b1);
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic issue_req(input req_type_t kind, input logic [PATH_W-1:0] path,
                             input bit typed, input trie_rsp_t want);
        trie_req_t item;
        trie_rsp_t got;
        int        gap;
        item.req_type = kind;
        item.path_in  = path;
        gap = quiet ? 0 : $urandom_range(0, 14);
        repeat (gap)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
        begin
            @(posedge clk);
        end
        while (!(req_valid && !req_stall));
        got = trie_step(item);
        if (kind == REQ_INSERT && got.status == ST_OK)
        begin
            known_paths.push_back(path);
            if (known_paths.size() > 64)
            begin
                void'(known_paths.pop_front());
            end
        end
        if (nodes_used > 0)
        begin
            nodes_ever = 1'b1;
        end
        rsp_due.push_back(typed ? want : got);
        sent++;
        @(negedge clk);
    endtask

    // a walk must not start before the root has ever been written
    task automatic issue_next();
        issue_req(nodes_ever ? REQ_NEXT : REQ_RESTART, $urandom(), 1'b0, RSP_NONE);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        req_valid <= 1'b0;
        while (rsp_due.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        if (idx == REG_LEVEL_COUNT || idx == REG_ALLELES)
        begin
            if (idx == REG_LEVEL_COUNT)
            begin
                cfg_levels = data[3:0];
            end
            else
            begin
                cfg_alleles = data;
            end
            trie_clear();
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        plan_row_t  plan [$];
        int         ph, sel, n, stop_at;
        req_type_t  kind;
        logic [3:0] lv_set [8];
        logic [PATH_W-1:0] ap_set [8];

        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        cfg_levels  = LEVEL_COUNT_RST;
        cfg_alleles = ALLELES_RST;
        trie_clear();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset shape: eight levels of sixteen alleles
        plan.push_back('{0, REG_UNMAPPED, '0, REQ_RESTART, 32'h0, 1, RSP_NONE});
        plan.push_back('{0, REG_UNMAPPED, '0, REQ_INSERT, 32'h0, 1, RSP_NONE});
        plan.push_back('{0, REG_UNMAPPED, '0, REQ_INSERT, 32'hFFFF_FFFF, 1,
                         '{leaf_index: 12'd1, path_out: '0, status: ST_OK}});
        plan.push_back('{0, REG_UNMAPPED, '0, REQ_INSERT, 32'h0, 1, RSP_NONE});
        plan.push_back('{0, REG_UNMAPPED, '0, REQ_RESTART, 32'hFFFF_FFFF, 1, RSP_NONE});
        plan.push_back('{0, REG_UNMAPPED, '0, REQ_NEXT, 32'h0, 0, RSP_NONE});
        // lands after the walk position, so the walk must find it
        plan.push_back('{0, REG_UNMAPPED, '0, REQ_INSERT, 32'h0000_0001, 0, RSP_NONE});
        plan.push_back('{0, REG_UNMAPPED, '0, REQ_NEXT, 32'h0, 0, RSP_NONE});
        plan.push_back('{0, REG_UNMAPPED, '0, REQ_NEXT, 32'h0, 0, RSP_NONE});
        plan.push_back('{0, REG_UNMAPPED, '0, REQ_NEXT, 32'h0, 0, RSP_NONE});
        plan.push_back('{0, REG_UNMAPPED, '0, REQ_NEXT, 32'hFFFF_FFFF, 1, RSP_ENDED});
        plan.push_back('{0, REG_UNMAPPED, '0, REQ_CLEAR, 32'hFFFF_FFFF, 1, RSP_NONE});
        plan.push_back('{0, REG_UNMAPPED, '0, REQ_NEXT, 32'h0, 1, RSP_ENDED});
        // three levels of one, two and three alleles
        plan.push_back('{1, REG_LEVEL_COUNT, 32'h3, REQ_CLEAR, 32'h0, 0, RSP_NONE});
        plan.push_back('{1, REG_ALLELES, 32'h0000_0210, REQ_CLEAR, 32'h0, 0, RSP_NONE});
        plan.push_back('{0, REG_UNMAPPED, '0, REQ_INSERT, 32'h0000_0001, 1, RSP_RANGE});
        plan.push_back('{0, REG_UNMAPPED, '0, REQ_INSERT, 32'h0000_0030, 1, RSP_RANGE});
        plan.push_back('{0, REG_UNMAPPED, '0, REQ_INSERT, 32'h0000_0300, 1, RSP_RANGE});
        plan.push_back('{0, REG_UNMAPPED, '0, REQ_INSERT, 32'hFFFF_F210, 1, RSP_NONE});
        plan.push_back('{0, REG_UNMAPPED, '0, REQ_RESTART, 32'h0, 1, RSP_NONE});
        plan.push_back('{0, REG_UNMAPPED, '0, REQ_NEXT, 32'h0, 0, RSP_NONE});
        // write to an index with no register behind it must leave the trie alone
        plan.push_back('{1, REG_UNMAPPED, 32'hFFFF_FFFF, REQ_CLEAR, 32'h0, 0, RSP_NONE});
        plan.push_back('{0, REG_UNMAPPED, '0, REQ_NEXT, 32'h0, 0, RSP_NONE});
        plan.push_back('{1, REG_LEVEL_COUNT, 32'h0, REQ_CLEAR, 32'h0, 0, RSP_NONE});
        plan.push_back('{1, REG_ALLELES, 32'hFFFF_FFFF, REQ_CLEAR, 32'h0, 0, RSP_NONE});
        plan.push_back('{0, REG_UNMAPPED, '0, REQ_INSERT, 32'hFFFF_FFFF, 0, RSP_NONE});
        plan.push_back('{0, REG_UNMAPPED, '0, REQ_RESTART, 32'h0, 1, RSP_NONE});
        plan.push_back('{0, REG_UNMAPPED, '0, REQ_NEXT, 32'h0, 0, RSP_NONE});

        foreach (plan[k])
        begin
            if (plan[k].cfg_row)
            begin
                write_reg(plan[k].idx, plan[k].data);
            end
            else
            begin
                issue_req(plan[k].kind, plan[k].path, plan[k].typed, plan[k].want);
            end
        end

        lv_set = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd3, 4'd2, 4'd8, 4'd4};
        ap_set = '{32'hFFFF_FFFF, 32'h0, 32'h1111_1111, 32'hFFFF_FFFF,
                   $urandom(), $urandom(), 32'h0, $urandom()};

        for (ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_LEVEL_COUNT, ($urandom() & 32'hFFFF_FFF0) | lv_set[ph]);
            write_reg(REG_ALLELES, ap_set[ph]);
            quiet = (ph % 3 == 2);
            if (ph == 0)
            begin
                hold_asks++;
            end
            stop_at = sent + PHASE_ITEMS;
            while (sent < stop_at)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 55)
                begin
                    // fill, rewind, then walk with the odd insert mixed in
                    n = $urandom_range(1, 10);
                    repeat (n) issue_req(REQ_INSERT, pick_path(), 1'b0, RSP_NONE);
                    issue_req(REQ_RESTART, $urandom(), 1'b0, RSP_NONE);
                    n = $urandom_range(1, 30);
                    repeat (n)
                    begin
                        if ($urandom_range(0, 9) == 0)
                        begin
                            issue_req(REQ_INSERT, pick_path(), 1'b0, RSP_NONE);
                        end
                        else
                        begin
                            issue_next();
                        end
                    end
                end
                else if (sel < 72)
                begin
                    n = $urandom_range(1, 10);
                    repeat (n) issue_next();
                end
                else if (sel < 86)
                begin
                    n = $urandom_range(1, 3);
                    repeat (n) issue_req(REQ_INSERT, rand_path(1'b0), 1'b0, RSP_NONE);
                end
                else if (sel < 98)
                begin
                    kind = req_type_t'($urandom_range(1, 3));
                    if (kind == REQ_NEXT && !nodes_ever)
                    begin
                        kind = REQ_RESTART;
                    end
                    issue_req(kind, $urandom(), 1'b0, RSP_NONE);
                end
                else
                begin
                    issue_req(REQ_CLEAR, $urandom(), 1'b0, RSP_NONE);
                end
            end
        end

        req_valid <= 1'b0;
        while (rsp_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
        if (err_cnt == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // result side back-pressure
    initial
    begin
        int n;
        int hold_done;
        hold_done = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            n = quiet ? 0 : $urandom_range(0, 14);
            if (hold_done != hold_asks)
            begin
                // long hold so the block backs up into its request side
                n = LONG_HOLD;
                hold_done++;
            end
            if (n > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            rsp_stall <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (!(rsp_valid && !rsp_stall));
        end
    end

    always @(posedge clk)
    begin
        trie_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (rsp_due.size() == 0)
            begin
                $error("unexpected transaction: leaf_index %0d, path_out %h, status %0d",
                       rsp.leaf_index, rsp.path_out, rsp.status);
                err_cnt++;
            end
            else
            begin
                want = rsp_due.pop_front();
                if (rsp.leaf_index !== want.leaf_index)
                begin
                    $error("leaf_index mismatch: expected %0d, actual %0d",
                           want.leaf_index, rsp.leaf_index);
                    err_cnt++;
                end
                if (rsp.path_out !== want.path_out)
                begin
                    $error("path_out mismatch: expected %h, actual %h",
                           want.path_out, rsp.path_out);
                    err_cnt++;
                end
                if (rsp.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, rsp.status);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

[filelist.f]
design/ftt_pkg.sv
design/ftt_ram.sv
design/ftt_clr.sv
design/ftt_core.sv
design/fixed_depth_trie_insert_traverse.sv
dv/tb_fixed_depth_trie_insert_traverse.sv
